// ----- design/ascii_two_operand_calculator_defines.svh -----
// Assertion macros shared by the calculator RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef ASCII_TWO_OPERAND_CALCULATOR_DEFINES_SVH
`define ASCII_TWO_OPERAND_CALCULATOR_DEFINES_SVH

// Same-cycle implication.
`define CALC_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CALC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/calc_pkg.sv -----
// Types and constants of the ASCII two-operand calculator.
// No dependencies; used by the parser, the divider, the calculator top level and the bench.
`default_nettype none

package calc_pkg;

    localparam int DATA_W = 32;
    localparam int DIV_CNT_W = $clog2(DATA_W);

    localparam logic [DATA_W-1:0] NO_DIGIT_VALUE = 32'hFFFF_FF9D;  // -99

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;
    localparam logic [7:0] CHAR_OP_LO = 8'd42;
    localparam logic [7:0] CHAR_OP_HI = 8'd47;
    localparam logic [7:0] OP_BIAS    = 8'd41;

    // Operator code is the character minus 41.
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_MUL   = 3'd1,
        OP_ADD   = 3'd2,
        OP_COMMA = 3'd3,
        OP_SUB   = 3'd4,
        OP_DOT   = 3'd5,
        OP_DIV   = 3'd6
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_BAD_OP   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_DIVIDE,
        S_HOLD
    } seq_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

// ----- design/calc_in_if.sv -----
// Character input channel: valid/ready plus one ASCII character.
// No dependencies.
`default_nettype none

interface calc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

// ----- design/calc_out_if.sv -----
// Result output channel: valid/ready plus signed result and status.
// No dependencies.
`default_nettype none

interface calc_out_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] result;
    logic [1:0]        status;

    modport source (output valid, output result, output status, input ready);
    modport sink   (input valid, input result, input status, output ready);
endinterface

`default_nettype wire

// ----- design/calc_parser.sv -----
// Character front end: builds the two operands and the operator code.
// Depends on calc_pkg.
`default_nettype none

module calc_parser #(
    parameter int MAX_CHARS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         take,
    input  wire logic [7:0]                   char_code,
    input  wire logic                         clear,
    output logic      [calc_pkg::DATA_W-1:0]  first_operand,
    output logic      [calc_pkg::DATA_W-1:0]  second_operand,
    output calc_pkg::opcode_t                 op
);

    localparam int CNT_W = $clog2(MAX_CHARS + 1);

    logic                         after_op_reg, after_op_next;
    logic                         first_has_reg, first_has_next;
    logic                         second_has_reg, second_has_next;
    logic [calc_pkg::DATA_W-1:0]  first_reg, first_next;
    logic [calc_pkg::DATA_W-1:0]  second_reg, second_next;
    calc_pkg::opcode_t            op_reg, op_next;
    logic [CNT_W-1:0]             seen_reg, seen_next;

    logic                         is_digit;
    logic                         is_op;
    logic [3:0]                   digit;
    logic [calc_pkg::DATA_W-1:0]  acc_src;
    logic [calc_pkg::DATA_W-1:0]  acc_val;
    logic                         acc_has;

    always_comb
    begin
        is_digit = char_code inside {[calc_pkg::CHAR_ZERO:calc_pkg::CHAR_NINE]};
        is_op    = char_code inside {[calc_pkg::CHAR_OP_LO:calc_pkg::CHAR_OP_HI]};
        digit    = 4'(char_code - calc_pkg::CHAR_ZERO);
        acc_src  = after_op_reg ? second_reg : first_reg;
        acc_has  = after_op_reg ? second_has_reg : first_has_reg;
        // value*10 + digit, wrapping
        if (acc_has)
        begin
            acc_val = {acc_src[calc_pkg::DATA_W-4:0], 3'b000}
                    + {acc_src[calc_pkg::DATA_W-2:0], 1'b0}
                    + calc_pkg::DATA_W'(digit);
        end
        else
        begin
            acc_val = calc_pkg::DATA_W'(digit);
        end
    end

    always_comb
    begin
        after_op_next   = after_op_reg;
        first_has_next  = first_has_reg;
        second_has_next = second_has_reg;
        first_next      = first_reg;
        second_next     = second_reg;
        op_next         = op_reg;
        seen_next       = seen_reg;
        if (clear)
        begin
            after_op_next   = 1'b0;
            first_has_next  = 1'b0;
            second_has_next = 1'b0;
            first_next      = calc_pkg::NO_DIGIT_VALUE;
            second_next     = calc_pkg::NO_DIGIT_VALUE;
            op_next         = calc_pkg::OP_NONE;
            seen_next       = '0;
        end
        else if (take && (seen_reg < CNT_W'(MAX_CHARS)))
        begin
            seen_next = seen_reg + 1'b1;
            if (!after_op_reg)
            begin
                if (is_digit)
                begin
                    first_next     = acc_val;
                    first_has_next = 1'b1;
                end
                else if (is_op)
                begin
                    op_next       = calc_pkg::opcode_t'(3'(char_code - calc_pkg::OP_BIAS));
                    after_op_next = 1'b1;
                end
            end
            else if (is_digit)
            begin
                second_next     = acc_val;
                second_has_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            after_op_reg   <= 1'b0;
            first_has_reg  <= 1'b0;
            second_has_reg <= 1'b0;
            first_reg      <= calc_pkg::NO_DIGIT_VALUE;
            second_reg     <= calc_pkg::NO_DIGIT_VALUE;
            op_reg         <= calc_pkg::OP_NONE;
            seen_reg       <= '0;
        end
        else
        begin
            after_op_reg   <= after_op_next;
            first_has_reg  <= first_has_next;
            second_has_reg <= second_has_next;
            first_reg      <= first_next;
            second_reg     <= second_next;
            op_reg         <= op_next;
            seen_reg       <= seen_next;
        end
    end

    assign first_operand  = first_reg;
    assign second_operand = second_reg;
    assign op             = op_reg;

endmodule

`default_nettype wire

// ----- design/calc_divider.sv -----
// Iterative signed divider: one shared subtractor, one quotient bit a cycle.
// Depends on calc_pkg.
`default_nettype none

module calc_divider (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [calc_pkg::DATA_W-1:0]  dividend,
    input  wire logic [calc_pkg::DATA_W-1:0]  divisor,
    output calc_pkg::div_status_t             stat,
    output logic signed [7:0]                 quotient_low
);

    localparam int W = calc_pkg::DATA_W;

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [calc_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]                  rem_reg, rem_next;
    logic [W-1:0]                  quo_reg, quo_next;
    logic [W-1:0]                  dvs_reg, dvs_next;
    logic                          neg_reg, neg_next;

    logic [W:0]                    trial;

    // shared subtract unit
    assign trial = {rem_reg, quo_reg[W-1]} - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend[W-1] ? (W'(0) - dividend) : dividend;
            dvs_next  = divisor[W-1] ? (W'(0) - divisor) : divisor;
            neg_next  = dividend[W-1] ^ divisor[W-1];
        end
        else if (busy_reg)
        begin
            if (trial[W])
            begin
                rem_next = {rem_reg[W-2:0], quo_reg[W-1]};
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            else
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == calc_pkg::DIV_CNT_W'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign stat.busy    = busy_reg;
    assign stat.done    = done_reg;
    assign quotient_low = neg_reg ? (8'sd0 - $signed(quo_reg[7:0])) : $signed(quo_reg[7:0]);

endmodule

`default_nettype wire

// ----- design/ascii_two_operand_calculator.sv -----
// The last character moves the sequencer from idle to calc, which works out + - * and error
// cases and goes to hold; for division it starts the divider and waits in divide for done.
// Throughput: one character per cycle while idle; after the last character no character is
// taken until hold moves the result to the output register once that register is free.
// Output register holds the result until taken.
// Reset: asynchronous, active low; clears operands to -99, the operator and the sequencer.
`default_nettype none
`include "ascii_two_operand_calculator_defines.svh"

module ascii_two_operand_calculator #(
    parameter int MAX_CHARS = 16
) (
    input wire logic   clk,
    input wire logic   rst_n,
    calc_in_if.sink    chars,
    calc_out_if.source results
);

    calc_pkg::seq_state_t         state_reg, state_next;
    logic                         out_valid_reg, out_valid_next;
    logic signed [7:0]            result_reg, result_next;
    calc_pkg::status_t            status_reg, status_next;
    logic signed [7:0]            pend_result_reg, pend_result_next;
    calc_pkg::status_t            pend_status_reg, pend_status_next;

    logic                         take;
    logic                         clear;
    logic                         div_start;
    logic [calc_pkg::DATA_W-1:0]  first_operand;
    logic [calc_pkg::DATA_W-1:0]  second_operand;
    calc_pkg::opcode_t            op;
    calc_pkg::div_status_t        div_stat;
    logic signed [7:0]            quotient_low;
    logic [15:0]                  product;
    logic                         slot_free;

    assign take      = chars.valid && chars.ready;
    assign slot_free = !out_valid_reg || results.ready;
    assign product   = first_operand[7:0] * second_operand[7:0];

    calc_parser #(
        .MAX_CHARS(MAX_CHARS)
    ) u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .take           (take),
        .char_code      (chars.char_code),
        .clear          (clear),
        .first_operand  (first_operand),
        .second_operand (second_operand),
        .op             (op)
    );

    calc_divider u_divider (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (div_start),
        .dividend     (first_operand),
        .divisor      (second_operand),
        .stat         (div_stat),
        .quotient_low (quotient_low)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= calc_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg      <= result_next;
        status_reg      <= status_next;
        pend_result_reg <= pend_result_next;
        pend_status_reg <= pend_status_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        pend_result_next = pend_result_reg;
        pend_status_next = pend_status_reg;
        result_next      = result_reg;
        status_next      = status_reg;
        out_valid_next   = out_valid_reg;
        clear            = 1'b0;
        div_start        = 1'b0;
        chars.ready      = 1'b0;

        if (results.valid && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            calc_pkg::S_IDLE:
            begin
                chars.ready = 1'b1;
                if (chars.valid && chars.last_char)
                begin
                    state_next = calc_pkg::S_CALC;
                end
            end
            calc_pkg::S_CALC:
            begin
                clear            = 1'b1;
                state_next       = calc_pkg::S_HOLD;
                pend_status_next = calc_pkg::ST_OK;
                pend_result_next = 8'sd0;
                case (op)
                    calc_pkg::OP_ADD:
                        pend_result_next = $signed(first_operand[7:0] + second_operand[7:0]);
                    calc_pkg::OP_SUB:
                        pend_result_next = $signed(first_operand[7:0] - second_operand[7:0]);
                    calc_pkg::OP_MUL:
                        pend_result_next = $signed(product[7:0]);
                    calc_pkg::OP_DIV:
                    begin
                        if (second_operand == '0)
                        begin
                            pend_status_next = calc_pkg::ST_DIV_ZERO;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = calc_pkg::S_DIVIDE;
                        end
                    end
                    default:
                        pend_status_next = calc_pkg::ST_BAD_OP;
                endcase
            end
            calc_pkg::S_DIVIDE:
            begin
                if (div_stat.done)
                begin
                    pend_result_next = quotient_low;
                    state_next       = calc_pkg::S_HOLD;
                end
            end
            calc_pkg::S_HOLD:
            begin
                if (slot_free)
                begin
                    result_next    = pend_result_reg;
                    status_next    = pend_status_reg;
                    out_valid_next = 1'b1;
                    state_next     = calc_pkg::S_IDLE;
                end
            end
            default:
                state_next = calc_pkg::S_IDLE;
        endcase
    end

    assign results.valid  = out_valid_reg;
    assign results.result = result_reg;
    assign results.status = status_reg;

    `CALC_ASSERT_IMPLY(a_no_take_while_dividing, chars.ready, !div_stat.busy, "input taken during division")
    `CALC_ASSERT_IMPLY(a_done_in_divide, div_stat.done, state_reg == calc_pkg::S_DIVIDE, "divider done outside divide state")
    `CALC_ASSERT_IMPLY(a_error_zero_result, results.valid && (results.status != calc_pkg::ST_OK), results.result == 8'sd0, "error result not zero")
    `CALC_ASSERT_NEXT(a_last_stalls_input, take && chars.last_char, !chars.ready, "input ready right after last character")

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking bench for the ASCII two-operand calculator: directed expressions
// from a table, then random expressions checked against a built-in predictor.
// Depends on calc_pkg, calc_in_if, calc_out_if and the calculator RTL.
module tb;
    import calc_pkg::*;

    localparam int LINE_LIMIT   = 16;
    localparam int PHASE_ITEMS  = 340;
    localparam int DRAIN_CYCLES = 64;

    typedef struct packed {
        logic signed [7:0] result;
        status_t           status;
    } calc_result_t;

    typedef struct packed {
        logic [7:0]        code;
        logic              last;
        logic              typed;
        logic signed [7:0] result;
        status_t           status;
    } stim_row_t;

    // Expected values are typed only where they are obvious; zero rows use the predictor.
    localparam stim_row_t DIRECTED [25] = '{
        '{"7",   1'b1, 1'b1, 8'sd0,  ST_BAD_OP},    // no operator at all
        '{"9",   1'b0, 1'b0, 8'sd0,  ST_OK},
        '{"+",   1'b0, 1'b0, 8'sd0,  ST_OK},
        '{"8",   1'b1, 1'b1, 8'sd17, ST_OK},
        '{"4",   1'b0, 1'b0, 8'sd0,  ST_OK},
        '{"-",   1'b0, 1'b0, 8'sd0,  ST_OK},
        '{"/",   1'b0, 1'b0, 8'sd0,  ST_OK},        // second operator ignored
        '{"x",   1'b0, 1'b0, 8'sd0,  ST_OK},        // junk after operator ignored
        '{"5",   1'b1, 1'b1, -8'sd1, ST_OK},
        '{"6",   1'b0, 1'b0, 8'sd0,  ST_OK},
        '{"*",   1'b0, 1'b0, 8'sd0,  ST_OK},
        '{"7",   1'b1, 1'b1, 8'sd42, ST_OK},
        '{"8",   1'b0, 1'b0, 8'sd0,  ST_OK},
        '{"/",   1'b0, 1'b0, 8'sd0,  ST_OK},
        '{"0",   1'b1, 1'b1, 8'sd0,  ST_DIV_ZERO},
        '{"1",   1'b0, 1'b0, 8'sd0,  ST_OK},
        '{",",   1'b0, 1'b0, 8'sd0,  ST_OK},
        '{"2",   1'b1, 1'b1, 8'sd0,  ST_BAD_OP},
        '{"3",   1'b0, 1'b0, 8'sd0,  ST_OK},
        '{".",   1'b1, 1'b1, 8'sd0,  ST_BAD_OP},
        '{"/",   1'b0, 1'b0, 8'sd0,  ST_OK},        // empty first operand
        '{"5",   1'b1, 1'b0, 8'sd0,  ST_OK},
        '{8'hFF, 1'b0, 1'b0, 8'sd0,  ST_OK},
        '{8'h00, 1'b0, 1'b0, 8'sd0,  ST_OK},
        '{"*",   1'b1, 1'b0, 8'sd0,  ST_OK}         // both operands empty
    };

    logic clk;
    logic rst_n;

    calc_in_if  chars();
    calc_out_if results();

    ascii_two_operand_calculator uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars),
        .results (results)
    );

    // predictor state
    bit          pr_after_op;
    logic [31:0] pr_lhs;
    logic [31:0] pr_rhs;
    bit          pr_lhs_dig;
    bit          pr_rhs_dig;
    opcode_t     pr_op;
    int unsigned pr_count;

    calc_result_t expected_results[$];

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned chars_sent;
    int unsigned exprs_sent;
    int unsigned mismatches;
    int unsigned status_seen[3];

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #6_000_000;
        $display("tb: FAIL");
        $finish;
    end

    function automatic void clear_expression();
        pr_after_op = 1'b0;
        pr_lhs      = NO_DIGIT_VALUE;
        pr_rhs      = NO_DIGIT_VALUE;
        pr_lhs_dig  = 1'b0;
        pr_rhs_dig  = 1'b0;
        pr_op       = OP_NONE;
        pr_count    = 0;
    endfunction

    function automatic logic [31:0] shift_in_digit(input logic [31:0] v, input bit has,
                                                   input logic [31:0] d);
        return has ? v * 32'd10 + d : d;
    endfunction

    // Fold one accepted character into the expression; on the last one queue the answer.
    function automatic void absorb_char(input logic [7:0] c, input logic lst, input bit fixed,
                                        input calc_result_t fixed_res);
        bit           is_digit;
        logic [7:0]   opc;
        logic [31:0]  dig;
        logic [31:0]  ma;
        logic [31:0]  mb;
        logic [31:0]  value;
        calc_result_t answer;
        is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        dig      = {24'd0, c - CHAR_ZERO};
        if (pr_count < LINE_LIMIT)
        begin
            if (!pr_after_op)
            begin
                if (is_digit)
                begin
                    pr_lhs     = shift_in_digit(pr_lhs, pr_lhs_dig, dig);
                    pr_lhs_dig = 1'b1;
                end
                else if (c >= CHAR_OP_LO && c <= CHAR_OP_HI)
                begin
                    opc         = c - OP_BIAS;
                    pr_op       = opcode_t'(opc[2:0]);
                    pr_after_op = 1'b1;
                end
            end
            else if (is_digit)
            begin
                pr_rhs     = shift_in_digit(pr_rhs, pr_rhs_dig, dig);
                pr_rhs_dig = 1'b1;
            end
            pr_count++;
        end
        if (!lst)
            return;
        value = '0;
        answer.status = ST_OK;
        case (pr_op)
            OP_ADD: value = pr_lhs + pr_rhs;
            OP_SUB: value = pr_lhs - pr_rhs;
            OP_MUL: value = pr_lhs * pr_rhs;
            OP_DIV:
            begin
                if (pr_rhs == '0)
                    answer.status = ST_DIV_ZERO;
                else
                begin
                    ma    = pr_lhs[31] ? -pr_lhs : pr_lhs;
                    mb    = pr_rhs[31] ? -pr_rhs : pr_rhs;
                    value = ma / mb;
                    if (pr_lhs[31] ^ pr_rhs[31])
                        value = -value;
                end
            end
            default: answer.status = ST_BAD_OP;
        endcase
        answer.result = value[7:0];
        expected_results.push_back(fixed ? fixed_res : answer);
        clear_expression();
    endfunction

    task automatic send_char(input logic [7:0] c, input logic lst, input bit fixed,
                             input calc_result_t fixed_res);
        while ($urandom_range(99) < send_idle_pct)
        begin
            chars.valid <= 1'b0;
            @(posedge clk);
        end
        chars.valid     <= 1'b1;
        chars.char_code <= c;
        chars.last_char <= lst;
        @(posedge clk);
        while (!chars.ready)
            @(posedge clk);
        absorb_char(c, lst, fixed, fixed_res);
        chars_sent++;
        if (lst)
            exprs_sent++;
    endtask

    function automatic int unsigned operand_length();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        return $urandom_range(11, 4);
    endfunction

    // Any character that is neither a digit nor an operator code.
    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while ((c >= CHAR_OP_LO && c <= CHAR_NINE));
        return c;
    endfunction

    function automatic logic [7:0] digit_char();
        return CHAR_ZERO + 8'($urandom_range(9));
    endfunction

    task automatic send_random_expression();
        logic [7:0]   line[$];
        logic [7:0]   plain_ops[4];
        int unsigned  n;
        calc_result_t none;
        plain_ops = '{"+", "-", "*", "/"};
        none      = '0;
        if ($urandom_range(99) < 80)
        begin
            n = operand_length();
            repeat (n)
            begin
                if ($urandom_range(99) < 8)
                    line.push_back(junk_char());
                line.push_back(digit_char());
            end
            if ($urandom_range(99) < 85)
                line.push_back(plain_ops[$urandom_range(3)]);
            else
                line.push_back(8'($urandom_range(CHAR_OP_HI, CHAR_OP_LO)));
            n = operand_length();
            repeat (n)
            begin
                if ($urandom_range(99) < 10)
                    line.push_back(8'($urandom_range(255)));
                line.push_back(digit_char());
            end
            // run past the character limit now and then
            if ($urandom_range(9) == 0)
                while (line.size() < 17 + $urandom_range(5))
                    line.push_back(8'($urandom_range(255)));
        end
        else
        begin
            n = $urandom_range(20, 1);
            repeat (n)
                line.push_back(($urandom_range(99) < 30) ? digit_char() : 8'($urandom_range(255)));
        end
        foreach (line[i])
            send_char(line[i], i == line.size() - 1, 1'b0, none);
    endtask

    // result side: check each transfer, then pick the next ready
    always @(posedge clk)
    begin
        calc_result_t want;
        if (rst_n && results.valid && results.ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d status %0d", results.result, results.status);
            end
            else
            begin
                want = expected_results.pop_front();
                if (results.result !== want.result || results.status !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected result %0d status %0d, got %0d status %0d",
                                 want.result, want.status, results.result, results.status);
                end
                if (results.status <= ST_BAD_OP)
                    status_seen[results.status]++;
            end
        end
        results.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin
        calc_result_t typed_res;
        int unsigned  phase_start;
        int unsigned  waited;
        chars.valid     <= 1'b0;
        chars.char_code <= 8'd0;
        chars.last_char <= 1'b0;
        rst_n           <= 1'b0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        clear_expression();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            typed_res.result = DIRECTED[i].result;
            typed_res.status = DIRECTED[i].status;
            send_char(DIRECTED[i].code, DIRECTED[i].last, DIRECTED[i].typed, typed_res);
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 6;  recv_stall_pct = 87; end
                1:       begin send_idle_pct = 87; recv_stall_pct = 6;  end
                default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase
            phase_start = chars_sent;
            while (chars_sent - phase_start < PHASE_ITEMS)
                send_random_expression();
        end
        chars.valid <= 1'b0;

        waited = 0;
        while (expected_results.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_results.size() != 0)
        begin
            mismatches++;
            $display("%0d expected results never arrived", expected_results.size());
        end
        $display("summary: %0d characters in %0d expressions, including overlong lines",
                 chars_sent, exprs_sent);
        $display("summary: results ok %0d, divide by zero %0d, bad operator %0d; mismatches %0d",
                 status_seen[0], status_seen[1], status_seen[2], mismatches);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule
